### sv/bdq_pkg.sv
// Shared constants, operation codes and stage types for the byte deque.
package bdq_pkg;

	localparam int STORE_BYTES_DEF = 256;
	localparam int MAX_DATUM_DEF   = 8;

	localparam int LANES     = 8;
	localparam int LANE_W    = 3;
	localparam int COUNT_W   = 4;
	localparam int DATA_W    = 64;
	localparam int OCC_W     = 9;
	localparam int ACT_W     = 3;
	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 80;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_LEFT  = 3'd0,
		ACT_PUSH_RIGHT = 3'd1,
		ACT_POP_LEFT   = 3'd2,
		ACT_POP_RIGHT  = 3'd3,
		ACT_CLEAR      = 3'd4
	} action_t;

	// Decision for one item, carried from the pointer logic to the result stage
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [COUNT_W-1:0] count;
		logic [LANE_W-1:0]  lane_off;
		logic [OCC_W-1:0]   occupancy;
	} op_t;

endpackage

### sv/bdq_bank.sv
// One byte lane of the interleaved store: single write port, registered read.
module bdq_bank #(
	parameter int ROWS  = 32,
	parameter int ROW_W = $clog2(ROWS)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             rd_en,
	input  logic [ROW_W-1:0] row,
	input  logic [7:0]       wdata,
	output logic [7:0]       rdata
);

	logic [7:0] mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[row];
		end
	end

endmodule

### sv/bdq_ctrl.sv
// End pointers and fill count of the deque, and the accept/refuse decision per item.
module bdq_ctrl import bdq_pkg::*; #(
	parameter int STORE_BYTES     = STORE_BYTES_DEF,
	parameter int MAX_DATUM_BYTES = MAX_DATUM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [ACT_W-1:0]                   action,
	input  logic [COUNT_W-1:0]                 count,
	output op_t                                op,
	output logic [$clog2(STORE_BYTES+1)-1:0]   base
);

	localparam int PTR_W = $clog2(STORE_BYTES + 1);
	localparam logic [PTR_W-1:0] MID     = PTR_W'(STORE_BYTES / 2);
	localparam logic [PTR_W-1:0] TOP_PTR = PTR_W'(STORE_BYTES);

	logic [PTR_W-1:0] left_q, right_q, fill_q;
	logic [PTR_W-1:0] left_d, right_d, fill_d;
	logic [PTR_W-1:0] n_ext;
	logic             size_ok;
	logic             push, pop;
	action_t          act;

	assign act     = action_t'(action);
	assign n_ext   = PTR_W'(count);
	assign size_ok = (count != '0) && (count <= COUNT_W'(MAX_DATUM_BYTES));

	always_comb begin
		left_d  = left_q;
		right_d = right_q;
		fill_d  = fill_q;
		push    = 1'b0;
		pop     = 1'b0;
		base    = left_q;
		unique case (act)
			ACT_PUSH_LEFT: begin
				if (size_ok && n_ext <= left_q) begin
					push   = 1'b1;
					left_d = left_q - n_ext;
					fill_d = fill_q + n_ext;
					base   = left_q - n_ext;
				end
			end
			ACT_PUSH_RIGHT: begin
				if (size_ok && n_ext <= TOP_PTR - right_q) begin
					push    = 1'b1;
					right_d = right_q + n_ext;
					fill_d  = fill_q + n_ext;
					base    = right_q;
				end
			end
			ACT_POP_LEFT: begin
				if (size_ok && n_ext <= fill_q) begin
					pop    = 1'b1;
					left_d = left_q + n_ext;
					fill_d = fill_q - n_ext;
					base   = left_q;
				end
			end
			ACT_POP_RIGHT: begin
				if (size_ok && n_ext <= fill_q) begin
					pop     = 1'b1;
					right_d = right_q - n_ext;
					fill_d  = fill_q - n_ext;
					base    = right_q - n_ext;
				end
			end
			ACT_CLEAR: begin
				left_d  = MID;
				right_d = MID;
				fill_d  = '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		op.push      = push;
		op.pop       = pop;
		op.count     = count;
		op.lane_off  = base[LANE_W-1:0];
		op.occupancy = OCC_W'(fill_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= MID;
			right_q <= MID;
			fill_q  <= '0;
		end else if (accept) begin
			left_q  <= left_d;
			right_q <= right_d;
			fill_q  <= fill_d;
		end
	end

endmodule

### sv/byte_deque_variable_width.sv
// Top level of the byte deque: input handshake, lane banks, result stage.
//
// Usage: each input item on s_* pushes 1..8 bytes of data at the left or
// right end of the deque, pops 1..8 bytes from either end, or clears the
// deque back to the middle of the store. Every item yields one result item
// on m_* with the popped datum, the number of bytes moved and the occupancy.
// Bytes live in eight interleaved byte-lane memories (address modulo 8), so
// any run of up to eight consecutive bytes touches each lane at most once: one
// item is taken every cycle while the output is not stalled, and its result
// is registered in the bank read register, then in the output register.
// A refused push or pop, a clear and an unknown action report zero bytes
// moved and leave the store untouched.
// Reset (arst_n low) sets both ends to the middle of the store and the fill
// count to zero; the store contents are not cleared, and no pop can reach a
// byte that was never pushed.
// When m_tready is held low the result and the item behind it are held, and
// s_tready drops once both stages are occupied; no item is lost or repeated.
module byte_deque_variable_width import bdq_pkg::*; #(
	parameter int STORE_BYTES     = STORE_BYTES_DEF,
	parameter int MAX_DATUM_BYTES = MAX_DATUM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // byte_count[3:0], data_in[67:4], zero pad
	input  logic [ACT_W-1:0]     s_tuser,  // action[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // data_out[63:0], bytes_moved[67:64],
	                                       // occupancy[76:68], zero pad
);

	localparam int PTR_W = $clog2(STORE_BYTES + 1);
	localparam int ROWS  = (STORE_BYTES + LANES - 1) / LANES;
	localparam int ROW_W = $clog2(ROWS);

	logic               accept;
	logic               adv_s1;
	logic [COUNT_W-1:0] byte_count;
	logic [DATA_W-1:0]  data_in;
	op_t                op;
	logic [PTR_W-1:0]   base;

	logic               valid_s1;
	op_t                op_s1;
	logic [7:0]         rdata [LANES];

	logic [DATA_W-1:0]  data_out;
	logic [COUNT_W-1:0] bytes_moved;

	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign byte_count = s_tdata[COUNT_W-1:0];
	assign data_in    = s_tdata[COUNT_W +: DATA_W];

	// Advance the middle stage whenever the output register is free or drains
	assign adv_s1   = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	bdq_ctrl #(
		.STORE_BYTES     (STORE_BYTES),
		.MAX_DATUM_BYTES (MAX_DATUM_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.action (s_tuser),
		.count  (byte_count),
		.op     (op),
		.base   (base)
	);

	// Lane g holds datum byte (g - base) mod 8 at row (base + that byte) / 8
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		logic [LANE_W-1:0] idx;
		logic              active;
		logic [PTR_W-1:0]  addr;

		assign idx    = LANE_W'(g) - op.lane_off;
		assign active = {1'b0, idx} < op.count;
		assign addr   = base + PTR_W'(idx);

		bdq_bank #(
			.ROWS  (ROWS),
			.ROW_W (ROW_W)
		) u_bank (
			.clk   (clk),
			.wr_en (accept && op.push && active),
			.rd_en (accept && op.pop && active),
			.row   (addr[ROW_W+2:3]),
			.wdata (data_in[8*idx +: 8]),
			.rdata (rdata[g])
		);
	end

	// Rotate the lane read data back into datum order; drop bytes past the count
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			if (op_s1.pop && k < int'(op_s1.count)) begin
				data_out[8*k +: 8] = rdata[LANE_W'(op_s1.lane_off + LANE_W'(k))];
			end else begin
				data_out[8*k +: 8] = '0;
			end
		end
		bytes_moved = (op_s1.push || op_s1.pop) ? op_s1.count : '0;
	end

	// Middle stage: hold the decision alongside the registered lane reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_s1) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			m_tdata_q <= {
				(M_TDATA_W - DATA_W - COUNT_W - OCC_W)'(0),
				op_s1.occupancy,
				bytes_moved,
				data_out
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
